@@ hw/rtl/fse_pkg.sv @@
// Package for the format string expander: character codes, widths and digit helper.
package fse_pkg;

  // Field widths
  localparam int CHAR_W   = 8;
  localparam int ARG_W    = 32;
  localparam int BW_W     = 16;
  localparam int COUNT_BITS_DEF = 16;

  // Digit shift register: ten BCD digits, also holds eight hex digits at the top
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int DIG_W      = 4 * DEC_DIGITS;
  localparam int DCNT_W     = 4;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_SEL_C   = 8'h63;
  localparam logic [CHAR_W-1:0] CH_SEL_D   = 8'h64;
  localparam logic [CHAR_W-1:0] CH_SEL_H   = 8'h68;

  // One digit (0..15) to its ASCII character, uppercase for A..F
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] nib);
    logic [CHAR_W-1:0] ch;
    if (nib >= 4'd10) begin
      ch = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end else begin
      ch = CH_ZERO + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

@@ hw/rtl/format_string_expander_top.sv @@
// Format string expander: streams format bytes in, printf-style characters out.
//
//  Channel | Ports                                                   | Handshake
//  --------+---------------------------------------------------------+-----------
//  input   | in_fmt_char[7:0], in_arg_value[31:0]                    | in_valid/in_ready
//  result  | out_char[7:0], out_bytes_written[15:0], out_run_last,   | out_valid/out_ready
//          | out_string_end                                          |
//
// A literal, '%%', 'c' or NUL item gives one character; '%' and an unknown
// selector give none. 'h' drops leading zero nibbles, then shifts out its digits. 'd'
// runs a bit-serial double-dabble on the 32-bit magnitude, then a '-' if negative,
// skips leading zeros and shifts out one digit per cycle while the output can load.
// One item is worked on at a time; the next is taken while the last result still
// sits in the output register. Stalls on out_ready hold the working state.
// Reset (rst_n low, synchronous) clears the pending '%', the count and the control.
module format_string_expander_top
  import fse_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_fmt_char,
  input  logic signed [ARG_W-1:0] in_arg_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic [BW_W-1:0]   out_bytes_written,
  output logic              out_run_last,
  output logic              out_string_end
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ONE  = 3'd1;
  localparam logic [2:0] S_DAB  = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_SKIP = 3'd4;
  localparam logic [2:0] S_DIG  = 3'd5;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [2:0]            state_r, state_nxt;
  logic                  pend_r, pend_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [CHAR_W-1:0]     one_char_r, one_char_nxt;
  logic                  one_end_r, one_end_nxt;
  logic                  neg_r, neg_nxt;
  logic [ARG_W-1:0]      mag_r, mag_nxt;
  logic [DIG_W-1:0]      dig_r, dig_nxt;
  logic [DCNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic [4:0]            bcnt_r, bcnt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic [BW_W-1:0]       out_bw_r, out_bw_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_end_r, out_end_nxt;

  logic                  can_load;
  logic                  accept;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS+BW_W-1:0] inc_ext;
  logic [COUNT_BITS+BW_W-1:0] cur_ext;
  logic [DIG_W-1:0]      bcd_adj;
  logic [3:0]            top_dig;
  logic [ARG_W-1:0]      arg_bits;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_load = !out_valid_r || out_ready;
  assign arg_bits = in_arg_value;

  // Saturating count, and its low bits as the reported field
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign inc_ext = {{BW_W{1'b0}}, cnt_inc};
  assign cur_ext = {{BW_W{1'b0}}, cnt_r};
  assign top_dig = dig_r[DIG_W-1 -: 4];

  // Double-dabble correction: add 3 to every BCD digit of 5 or more
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (dig_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = dig_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = dig_r[4*i +: 4];
      end
    end
  end

  // Sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    one_char_nxt  = one_char_r;
    one_end_nxt   = one_end_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    dig_nxt       = dig_r;
    dcnt_nxt      = dcnt_r;
    bcnt_nxt      = bcnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_bw_nxt    = out_bw_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          one_end_nxt = 1'b0;
          if (in_fmt_char == CH_NUL) begin
            pend_nxt     = 1'b0;
            one_char_nxt = CH_NUL;
            one_end_nxt  = 1'b1;
            state_nxt    = S_ONE;
          end else if (pend_r) begin
            pend_nxt = 1'b0;
            case (in_fmt_char)
              CH_PERCENT: begin
                one_char_nxt = CH_PERCENT;
                state_nxt    = S_ONE;
              end
              CH_SEL_C: begin
                one_char_nxt = arg_bits[CHAR_W-1:0];
                state_nxt    = S_ONE;
              end
              CH_SEL_D: begin
                neg_nxt   = arg_bits[ARG_W-1];
                mag_nxt   = arg_bits[ARG_W-1] ? (~arg_bits + 1'b1) : arg_bits;
                dig_nxt   = '0;
                bcnt_nxt  = '0;
                dcnt_nxt  = DCNT_W'(DEC_DIGITS);
                state_nxt = S_DAB;
              end
              CH_SEL_H: begin
                neg_nxt   = 1'b0;
                dig_nxt   = {arg_bits, {(DIG_W-ARG_W){1'b0}}};
                dcnt_nxt  = DCNT_W'(HEX_DIGITS);
                state_nxt = S_SKIP;
              end
              default: begin
                state_nxt = S_IDLE;
              end
            endcase
          end else if (in_fmt_char == CH_PERCENT) begin
            pend_nxt = 1'b1;
          end else begin
            one_char_nxt = in_fmt_char;
            state_nxt    = S_ONE;
          end
        end
      end

      // Single-character result: literal, '%', 'c' or terminator
      S_ONE: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = one_char_r;
          out_last_nxt  = 1'b1;
          out_end_nxt   = one_end_r;
          if (one_end_r) begin
            out_bw_nxt = cur_ext[BW_W-1:0];
            cnt_nxt    = '0;
          end else begin
            out_bw_nxt = inc_ext[BW_W-1:0];
            cnt_nxt    = cnt_inc;
          end
          state_nxt = S_IDLE;
        end
      end

      // One magnitude bit into the BCD register per cycle
      S_DAB: begin
        dig_nxt  = {bcd_adj[DIG_W-2:0], mag_r[ARG_W-1]};
        mag_nxt  = {mag_r[ARG_W-2:0], 1'b0};
        bcnt_nxt = bcnt_r + 1'b1;
        if (bcnt_r == 5'd31) begin
          state_nxt = neg_r ? S_SIGN : S_SKIP;
        end
      end

      S_SIGN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_MINUS;
          out_bw_nxt    = inc_ext[BW_W-1:0];
          out_last_nxt  = 1'b0;
          out_end_nxt   = 1'b0;
          cnt_nxt       = cnt_inc;
          state_nxt     = S_SKIP;
        end
      end

      // Drop leading zero digits, keeping at least one
      S_SKIP: begin
        if (top_dig == 4'd0 && dcnt_r != 4'd1) begin
          dig_nxt  = {dig_r[DIG_W-5:0], 4'd0};
          dcnt_nxt = dcnt_r - 1'b1;
        end else begin
          state_nxt = S_DIG;
        end
      end

      // One digit out per cycle while the output register can load, most significant first
      S_DIG: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_ascii(top_dig);
          out_bw_nxt    = inc_ext[BW_W-1:0];
          out_last_nxt  = (dcnt_r == 4'd1);
          out_end_nxt   = 1'b0;
          cnt_nxt       = cnt_inc;
          dig_nxt       = {dig_r[DIG_W-5:0], 4'd0};
          dcnt_nxt      = dcnt_r - 1'b1;
          if (dcnt_r == 4'd1) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    one_char_r <= one_char_nxt;
    one_end_r  <= one_end_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    dig_r      <= dig_nxt;
    dcnt_r     <= dcnt_nxt;
    bcnt_r     <= bcnt_nxt;
    out_char_r <= out_char_nxt;
    out_bw_r   <= out_bw_nxt;
    out_last_r <= out_last_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_char          = out_char_r;
  assign out_bytes_written = out_bw_r;
  assign out_run_last      = out_last_r;
  assign out_string_end    = out_end_r;

endmodule

@@ tb/tb_top.sv @@
// Testbench for format_string_expander_top: drives format bytes and scores output characters.
module tb_top;
  import fse_pkg::*;

  localparam int STUCK_LIMIT   = 2000;
  localparam int RANDOM_BYTES  = 435;
  localparam int DRAIN_CYCLES  = 60;
  localparam logic [CHAR_W-1:0] SEL_S = 8'h73;
  localparam logic [CHAR_W-1:0] SEL_F = 8'h66;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [BW_W-1:0]   count;
    logic              last;
    logic              term;
  } out_char_t;

  // Predicts the character stream and checks it against what the block emits
  class char_scoreboard;
    out_char_t         expected_chars[$];
    bit                pct_armed;
    logic [BW_W-1:0]   char_count;
    int                errors;

    function int pending();
      return expected_chars.size();
    endfunction

    // Expand one accepted format byte into the characters it must produce
    function void note_fmt_byte(logic [CHAR_W-1:0] ch, logic [ARG_W-1:0] arg);
      logic [CHAR_W-1:0] run[$];
      logic [CHAR_W-1:0] digs[$];
      logic [ARG_W-1:0]  mag;
      logic [3:0]        nib;
      // terminator reports the count and clears everything
      if (ch == CH_NUL) begin
        expected_chars.push_back('{CH_NUL, char_count, 1'b1, 1'b1});
        pct_armed  = 0;
        char_count = '0;
        return;
      end
      if (pct_armed) begin
        pct_armed = 0;
        case (ch)
          CH_PERCENT: run.push_back(CH_PERCENT);
          CH_SEL_C:   run.push_back(arg[CHAR_W-1:0]);
          CH_SEL_D: begin
            mag = arg;
            if (arg[ARG_W-1]) begin
              run.push_back(CH_MINUS);
              mag = ~arg + 1'b1;
            end
            do begin
              digs.push_front(CH_ZERO + CHAR_W'(mag % 10));
              mag = mag / 10;
            end while (mag != 0);
            run = {run, digs};
          end
          CH_SEL_H: begin
            mag = arg;
            do begin
              nib = mag[3:0];
              if (nib < 4'd10) digs.push_front(CH_ZERO + {4'd0, nib});
              else digs.push_front(CH_UPPER_A + {4'd0, nib} - 8'd10);
              mag = mag >> 4;
            end while (mag != 0);
            run = {run, digs};
          end
          default: ;  // unknown selector: nothing
        endcase
      end else if (ch == CH_PERCENT) begin
        pct_armed = 1;
      end else begin
        run.push_back(ch);
      end
      // count saturates; last flag on the final char of this item
      foreach (run[i]) begin
        if (char_count != '1) char_count = char_count + 1'b1;
        expected_chars.push_back('{run[i], char_count, i == run.size() - 1, 1'b0});
      end
    endfunction

    function void report(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    // Compare one emitted character with the oldest prediction
    function void check_char(logic [CHAR_W-1:0] ch, logic [BW_W-1:0] count,
                             logic last, logic term);
      out_char_t e;
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected char, expected none, actual %0h", $time, ch);
        return;
      end
      e = expected_chars.pop_front();
      if (ch != e.ch) report("out_char", e.ch, ch);
      if (count != e.count) report("out_bytes_written", e.count, count);
      if (last != e.last) report("out_run_last", e.last, last);
      if (term != e.term) report("out_string_end", e.term, term);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CHAR_W-1:0]        in_fmt_char = '0;
  logic signed [ARG_W-1:0]  in_arg_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CHAR_W-1:0]        out_char;
  logic [BW_W-1:0]          out_bytes_written;
  logic                     out_run_last;
  logic                     out_string_end;

  char_scoreboard sb = new();
  bit  idle_on = 1'b1;
  int  sent_bytes = 0;
  int  stuck_cycles = 0;

  format_string_expander_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_fmt_char       (in_fmt_char),
    .in_arg_value      (in_arg_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_bytes_written (out_bytes_written),
    .out_run_last      (out_run_last),
    .out_string_end    (out_string_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check accepted chars, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_char(out_char, out_bytes_written, out_run_last, out_string_end);
    out_ready <= idle_on ? ($urandom_range(99) >= 14) : 1'b1;
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Send one format byte, with random idle cycles ahead of it
  task automatic push_fmt_byte(input logic [CHAR_W-1:0] ch, input logic [ARG_W-1:0] arg);
    while (idle_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_fmt_char  <= ch;
    in_arg_value <= arg;
    do @(posedge clk); while (!in_ready);
    sb.note_fmt_byte(ch, arg);
    sent_bytes++;
  endtask

  // Hold the input until every predicted char has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mix of full-range, small, small negative and extreme arguments
  function automatic logic [ARG_W-1:0] rand_arg();
    case ($urandom_range(3))
      0: return ARG_W'($urandom);
      1: return ARG_W'($urandom_range(0, 999));
      2: return -ARG_W'($urandom_range(1, 999));
      default: return {1'($urandom_range(1)), {(ARG_W-1){1'($urandom_range(1))}}};
    endcase
  endfunction

  initial begin
    int                start_cnt;
    int                pick;
    bit                paused;
    logic [CHAR_W-1:0] lit;
    logic [CHAR_W-1:0] sel;
    paused = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: literal extremes, every conversion, unknown selectors, terminators
    push_fmt_byte(8'h01, 32'h0000_0000);
    push_fmt_byte(8'hFF, 32'hFFFF_FFFF);
    push_fmt_byte(CH_PERCENT, 32'h0);
    push_fmt_byte(CH_PERCENT, 32'h0);
    push_fmt_byte(CH_PERCENT, 32'h0);
    push_fmt_byte(CH_SEL_C, 32'hA5C3_7EFF);
    push_fmt_byte(CH_PERCENT, 32'h0);
    push_fmt_byte(CH_SEL_D, 32'h0000_0000);
    push_fmt_byte(CH_PERCENT, 32'h0);
    push_fmt_byte(CH_SEL_D, 32'h8000_0000);
    push_fmt_byte(CH_PERCENT, 32'h0);
    push_fmt_byte(CH_SEL_D, 32'h7FFF_FFFF);
    push_fmt_byte(CH_PERCENT, 32'h0);
    push_fmt_byte(CH_SEL_H, 32'h0000_0000);
    push_fmt_byte(CH_PERCENT, 32'h0);
    push_fmt_byte(CH_SEL_H, 32'hFFFF_FFFF);
    push_fmt_byte(CH_PERCENT, 32'h0);
    push_fmt_byte(SEL_S, 32'h1234_5678);
    push_fmt_byte(CH_PERCENT, 32'h0);
    push_fmt_byte(SEL_F, 32'h1234_5678);
    // pending '%' cut short by the terminator
    push_fmt_byte(CH_PERCENT, 32'h0);
    push_fmt_byte(CH_NUL, 32'h0);
    // empty string right after a terminator
    push_fmt_byte(CH_NUL, 32'hFFFF_FFFF);
    drain_results();

    // Random: mostly well-formed conversions and literals, some noise
    start_cnt = sent_bytes;
    while (sent_bytes - start_cnt < RANDOM_BYTES) begin
      idle_on = !((sent_bytes - start_cnt >= 250) && (sent_bytes - start_cnt < 330));
      if (!paused && sent_bytes - start_cnt >= 150) begin
        paused = 1;
        drain_results();
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        do lit = CHAR_W'($urandom_range(1, 255)); while (lit == CH_PERCENT);
        push_fmt_byte(lit, rand_arg());
      end else if (pick < 75) begin
        case ($urandom_range(3))
          0: sel = CH_PERCENT;
          1: sel = CH_SEL_C;
          2: sel = CH_SEL_D;
          default: sel = CH_SEL_H;
        endcase
        push_fmt_byte(CH_PERCENT, rand_arg());
        push_fmt_byte(sel, rand_arg());
      end else if (pick < 85) begin
        do sel = CHAR_W'($urandom_range(1, 255));
        while (sel == CH_PERCENT || sel == CH_SEL_C || sel == CH_SEL_D || sel == CH_SEL_H);
        push_fmt_byte(CH_PERCENT, rand_arg());
        push_fmt_byte(sel, rand_arg());
      end else if (pick < 93) begin
        if ($urandom_range(3) == 0) push_fmt_byte(CH_PERCENT, rand_arg());
        push_fmt_byte(CH_NUL, rand_arg());
      end else begin
        push_fmt_byte(CHAR_W'($urandom), rand_arg());
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
